### src/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] PHASE_TICKS_RST    = 8'd10;
    localparam logic [7:0] SETUP_TICKS_RST    = 8'd20;
    localparam logic [7:0] UNSTICK_PULSES_RST = 8'd64;

    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_STOP    = 3'd2;
    localparam logic [2:0] ACT_WRITE   = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;
    localparam logic [2:0] ACT_UNSTICK = 3'd5;
    localparam logic [2:0] ACT_ADDR    = 3'd6;
    localparam logic [2:0] ACT_TICK_ALT = 3'd7;

    localparam logic [1:0] CFG_PHASE_TICKS    = 2'd0;
    localparam logic [1:0] CFG_SETUP_TICKS    = 2'd1;
    localparam logic [1:0] CFG_UNSTICK_PULSES = 2'd2;

    typedef struct packed {
        logic       is_tick;
        logic [2:0] cmd;
        logic [7:0] load_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       we;
        logic [1:0] addr;
        logic [7:0] wdata;
    } cfg_write_t;

endpackage
`default_nettype wire

### src/i2cm_front.sv
`default_nettype none
module i2cm_front
    import i2cm_pkg::*;
(
    input  wire logic [2:0]  action,
    input  wire logic [7:0]  write_byte,
    input  wire logic        send_ack,
    input  wire logic        read_flag,
    input  wire logic        sda_in,
    output item_t            item
);

    always_comb begin
        item.is_tick   = (action == ACT_TICK) || (action == ACT_TICK_ALT);
        item.cmd       = action;
        item.send_ack  = send_ack;
        item.sda_in    = sda_in;
        unique case (action)
            ACT_WRITE: item.load_byte = write_byte;
            ACT_ADDR:  item.load_byte = {write_byte[7:1], read_flag};
            default:   item.load_byte = 8'd0;
        endcase
    end

endmodule
`default_nettype wire

### src/i2cm_queue.sv
`default_nettype none
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  item_t      push_item,
    output logic       not_full,
    input  wire logic  pop,
    output logic       not_empty,
    output item_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign not_full  = count_reg != CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### src/i2cm_back.sv
`default_nettype none
module i2cm_back
    import i2cm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  cfg_write_t       cfg,
    input  wire logic        item_valid,
    input  item_t            item,
    output logic             item_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata
);

    localparam logic [4:0] PH_NONE     = 5'd0;
    localparam logic [4:0] PH_START_A  = 5'd1;
    localparam logic [4:0] PH_START_B  = 5'd2;
    localparam logic [4:0] PH_START_C  = 5'd3;
    localparam logic [4:0] PH_STOP_A   = 5'd4;
    localparam logic [4:0] PH_STOP_B   = 5'd5;
    localparam logic [4:0] PH_STOP_C   = 5'd6;
    localparam logic [4:0] PH_WR_HI    = 5'd7;
    localparam logic [4:0] PH_WR_LO    = 5'd8;
    localparam logic [4:0] PH_WACK_HI  = 5'd9;
    localparam logic [4:0] PH_WACK_LO  = 5'd10;
    localparam logic [4:0] PH_RD_HI    = 5'd11;
    localparam logic [4:0] PH_RD_LO    = 5'd12;
    localparam logic [4:0] PH_RACK_SET = 5'd13;
    localparam logic [4:0] PH_RACK_HI  = 5'd14;
    localparam logic [4:0] PH_RACK_LO  = 5'd15;
    localparam logic [4:0] PH_UN_LO    = 5'd16;
    localparam logic [4:0] PH_UN_HI    = 5'd17;
    localparam logic [4:0] PH_SETUP    = 5'd18;

    logic [7:0] phase_ticks_reg, setup_ticks_reg, unstick_pulses_reg;

    logic [2:0] active_reg,   active_next;
    logic [4:0] phase_reg,    phase_next;
    logic [3:0] bitcnt_reg,   bitcnt_next;
    logic [7:0] shift_reg,    shift_next;
    logic [7:0] delay_reg,    delay_next;
    logic [7:0] pulse_reg,    pulse_next;
    logic       scl_reg,      scl_next;
    logic       sda_reg,      sda_next;
    logic       sda_en_reg,   sda_en_next;
    logic       ack_reg,      ack_next;
    logic       ack_tx_reg,   ack_tx_next;
    logic [7:0] rx_byte_reg,  rx_byte_next;

    logic       m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    logic       done;
    logic       err;
    logic       enter;
    logic [4:0] np;

    assign item_pop = item_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg    <= PHASE_TICKS_RST;
            setup_ticks_reg    <= SETUP_TICKS_RST;
            unstick_pulses_reg <= UNSTICK_PULSES_RST;
        end else if (cfg.we) begin
            unique case (cfg.addr)
                CFG_PHASE_TICKS:    phase_ticks_reg    <= cfg.wdata;
                CFG_SETUP_TICKS:    setup_ticks_reg    <= cfg.wdata;
                CFG_UNSTICK_PULSES: unstick_pulses_reg <= cfg.wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        active_next  = active_reg;
        phase_next   = phase_reg;
        bitcnt_next  = bitcnt_reg;
        shift_next   = shift_reg;
        delay_next   = delay_reg;
        pulse_next   = pulse_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        sda_en_next  = sda_en_reg;
        ack_next     = ack_reg;
        ack_tx_next  = ack_tx_reg;
        rx_byte_next = rx_byte_reg;
        done  = 1'b0;
        err   = 1'b0;
        enter = 1'b0;
        np    = PH_NONE;

        if (item.is_tick) begin
            if (active_reg != ACT_TICK) begin
                delay_next = delay_reg - 8'd1;
                if (delay_next == 8'd0) begin
                    unique case (phase_reg)
                        PH_START_A: np = PH_START_B;
                        PH_START_B: np = PH_START_C;
                        PH_START_C: np = (active_reg == ACT_ADDR) ? PH_WR_HI : PH_NONE;
                        PH_STOP_A:  np = PH_STOP_B;
                        PH_STOP_B:  np = PH_STOP_C;
                        PH_WR_HI:   np = PH_WR_LO;
                        PH_WR_LO: begin
                            shift_next  = {shift_reg[6:0], 1'b0};
                            bitcnt_next = bitcnt_reg - 4'd1;
                            np = (bitcnt_next != 4'd0) ? PH_WR_HI : PH_WACK_HI;
                        end
                        PH_WACK_HI: begin
                            ack_next = !item.sda_in;
                            np = PH_WACK_LO;
                        end
                        PH_RD_HI: begin
                            shift_next = {shift_reg[7:1], shift_reg[0] | item.sda_in};
                            np = PH_RD_LO;
                        end
                        PH_RD_LO: begin
                            bitcnt_next = bitcnt_reg - 4'd1;
                            np = (bitcnt_next != 4'd0) ? PH_RD_HI : PH_RACK_SET;
                        end
                        PH_RACK_SET: np = PH_RACK_HI;
                        PH_RACK_HI:  np = PH_RACK_LO;
                        PH_RACK_LO: begin
                            sda_next     = 1'b0;
                            rx_byte_next = shift_reg;
                        end
                        PH_UN_LO: np = PH_UN_HI;
                        PH_UN_HI: begin
                            pulse_next = pulse_reg - 8'd1;
                            np = (pulse_next != 8'd0) ? PH_UN_LO : PH_NONE;
                        end
                        PH_SETUP: np = PH_START_A;
                        default:  np = PH_NONE;
                    endcase
                    if (np == PH_NONE) begin
                        active_next = ACT_TICK;
                        phase_next  = PH_NONE;
                        done        = 1'b1;
                    end else begin
                        enter = 1'b1;
                    end
                end
            end
        end else if (active_reg != ACT_TICK) begin
            err = 1'b1;
        end else begin
            active_next = item.cmd;
            unique case (item.cmd)
                ACT_START: begin
                    np = PH_START_A;
                    enter = 1'b1;
                end
                ACT_STOP: begin
                    np = PH_STOP_A;
                    enter = 1'b1;
                end
                ACT_WRITE, ACT_ADDR: begin
                    shift_next  = item.load_byte;
                    bitcnt_next = 4'd8;
                    np = (item.cmd == ACT_ADDR) ? PH_SETUP : PH_WR_HI;
                    enter = 1'b1;
                end
                ACT_READ: begin
                    shift_next  = item.load_byte;
                    bitcnt_next = 4'd8;
                    ack_tx_next = item.send_ack;
                    np = PH_RD_HI;
                    enter = 1'b1;
                end
                ACT_UNSTICK: begin
                    sda_en_next = 1'b1;
                    pulse_next  = unstick_pulses_reg;
                    if (unstick_pulses_reg == 8'd0) begin
                        active_next = ACT_TICK;
                        done        = 1'b1;
                    end else begin
                        np = PH_UN_LO;
                        enter = 1'b1;
                    end
                end
                default: active_next = active_reg;
            endcase
        end

        if (enter) begin
            phase_next = np;
            delay_next = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
            unique case (np)
                PH_START_A: begin
                    sda_en_next = 1'b1;
                    sda_next    = 1'b1;
                    scl_next    = 1'b1;
                end
                PH_START_B: sda_next = 1'b0;
                PH_START_C: scl_next = 1'b0;
                PH_STOP_A:  sda_next = 1'b0;
                PH_STOP_B:  scl_next = 1'b1;
                PH_STOP_C: begin
                    sda_en_next = 1'b0;
                    sda_next    = 1'b1;
                end
                PH_WR_HI: begin
                    sda_en_next = 1'b1;
                    sda_next    = shift_next[7];
                    scl_next    = 1'b1;
                end
                PH_WR_LO: scl_next = 1'b0;
                PH_WACK_HI: begin
                    sda_en_next = 1'b0;
                    sda_next    = 1'b1;
                    scl_next    = 1'b1;
                end
                PH_WACK_LO: scl_next = 1'b0;
                PH_RD_HI: begin
                    sda_en_next = 1'b0;
                    sda_next    = 1'b1;
                    shift_next  = {shift_next[6:0], 1'b0};
                    scl_next    = 1'b1;
                end
                PH_RD_LO: scl_next = 1'b0;
                PH_RACK_SET: begin
                    sda_en_next = 1'b1;
                    sda_next    = !ack_tx_next;
                end
                PH_RACK_HI: scl_next = 1'b1;
                PH_RACK_LO: scl_next = 1'b0;
                PH_UN_LO: begin
                    sda_en_next = 1'b1;
                    scl_next    = 1'b0;
                    sda_next    = 1'b0;
                end
                PH_UN_HI: begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                PH_SETUP: begin
                    scl_next    = 1'b1;
                    sda_next    = 1'b1;
                    sda_en_next = 1'b0;
                    delay_next  = (setup_ticks_reg == 8'd0) ? 8'd1 : setup_ticks_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= ACT_TICK;
            phase_reg    <= PH_NONE;
            bitcnt_reg   <= '0;
            shift_reg    <= '0;
            delay_reg    <= '0;
            pulse_reg    <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            sda_en_reg   <= 1'b0;
            ack_reg      <= 1'b0;
            ack_tx_reg   <= 1'b0;
            rx_byte_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (item_pop) begin
                active_reg  <= active_next;
                phase_reg   <= phase_next;
                bitcnt_reg  <= bitcnt_next;
                shift_reg   <= shift_next;
                delay_reg   <= delay_next;
                pulse_reg   <= pulse_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                sda_en_reg  <= sda_en_next;
                ack_reg     <= ack_next;
                ack_tx_reg  <= ack_tx_next;
                rx_byte_reg <= rx_byte_next;
            end
            if (item_pop) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            m_tdata_reg <= {1'b0, err, rx_byte_next, ack_next, done,
                            active_next != ACT_TICK, sda_en_next, sda_next, scl_next};
        end
    end

endmodule
`default_nettype wire

### src/i2c_master_byte_engine.sv
`default_nettype none
// i2c master byte engine
// s_ channel takes requests: s_tuser carries the action (tick, start, stop,
// write, read, unstick, addressed start), s_tdata the byte and flags, and a
// tick request carries the sampled sda level
// m_ channel returns one result per request: scl/sda pin levels, sda drive,
// busy, done, ack, last read byte and the busy error flag
// cfg_we/cfg_addr/cfg_wdata write the phase, setup and unstick registers; the user
// must write them only while the engine is idle, the block does not enforce it
// a request is written into the queue on the edge that takes it; a step
// of the engine state machine then moves its result into the output register
// behind m_tvalid, waiting while that register holds an untaken result
// throughput: one request per cycle unless the receiver stalls, one phase step each
// a short request queue sits in front of the engine; when the receiver
// stalls the output register holds its result, the queue fills, and
// s_tready drops once it is full
// reset (aresetn low, synchronous) empties the queue, drops m_tvalid,
// restores register defaults and leaves scl high with sda released
module i2c_master_byte_engine
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // action
    input  wire logic [15:0] s_tdata,   // write_byte[7:0], send_ack, read_flag, sda_in, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // scl_out, sda_out, sda_drive, busy_res, done_res,
                                        // ack_received, read_data[7:0], error, zero pad
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);

    item_t      front_item;
    item_t      head_item;
    logic       head_valid;
    logic       pop;
    cfg_write_t cfg;

    assign cfg = '{we: cfg_we, addr: cfg_addr, wdata: cfg_wdata};

    i2cm_front u_front (
        .action     (s_tuser),
        .write_byte (s_tdata[7:0]),
        .send_ack   (s_tdata[8]),
        .read_flag  (s_tdata[9]),
        .sda_in     (s_tdata[10]),
        .item       (front_item)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && s_tready),
        .push_item (front_item),
        .not_full  (s_tready),
        .pop       (pop),
        .not_empty (head_valid),
        .head      (head_item)
    );

    i2cm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (head_valid),
        .item       (head_item),
        .item_pop   (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

### src/i2cm_checker.sv
`default_nettype none
module i2cm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a finished sequence leaves the engine idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> !m_tdata[3])
        else $error("done while still busy");

    // an ignored request only happens while busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> m_tdata[3])
        else $error("error flagged while idle");

    // reset drops any pending result
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (.*);
`default_nettype wire

### verif/i2c_checker.sv
`timescale 1ns / 100ps
module i2c_checker
    import i2cm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [2:0]  s_tuser,   // action
    input  wire logic [15:0] s_tdata,   // write_byte[7:0], send_ack, read_flag, sda_in, zero pad
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // scl_out, sda_out, sda_drive, busy_res, done_res,
                                        // ack_received, read_data[7:0], error, zero pad
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    output int               fail_count,
    output int               pending,
    output logic             model_busy
);

    localparam logic [2:0] NO_CMD = ACT_TICK;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_REL, PH_START_SDA, PH_START_SCL,
        PH_STOP_SDA, PH_STOP_SCL, PH_STOP_REL,
        PH_WR_HIGH, PH_WR_LOW, PH_WACK_HIGH, PH_WACK_LOW,
        PH_RD_HIGH, PH_RD_LOW, PH_RACK_DRIVE, PH_RACK_HIGH, PH_RACK_LOW,
        PH_UNS_LOW, PH_UNS_HIGH, PH_SETTLE
    } phase_t;

    // packed so that it lines up with m_tdata[14:0]
    typedef struct packed {
        logic       error;
        logic [7:0] read_data;
        logic       ack;
        logic       done;
        logic       busy;
        logic       sda_drive;
        logic       sda_out;
        logic       scl;
    } pins_t;

    logic [7:0] cfg_phase, cfg_setup, cfg_pulses;
    logic [2:0] cur_cmd;
    phase_t     phase;
    logic [3:0] bits_left;
    logic [7:0] shreg, dly, pulses_left, rx_byte;
    logic       scl_q, sda_q, sda_oe, acked, ack_level;

    pins_t pins_due[$];

    initial fail_count = 0;

    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic void clear_engine();
        cfg_phase   = PHASE_TICKS_RST;
        cfg_setup   = SETUP_TICKS_RST;
        cfg_pulses  = UNSTICK_PULSES_RST;
        cur_cmd     = NO_CMD;
        phase       = PH_IDLE;
        bits_left   = '0;
        shreg       = '0;
        dly         = '0;
        pulses_left = '0;
        scl_q       = 1'b1;
        sda_q       = 1'b1;
        sda_oe      = 1'b0;
        acked       = 1'b0;
        ack_level   = 1'b0;
        rx_byte     = '0;
    endfunction

    function automatic void begin_phase(input phase_t p);
        phase = p;
        dly = at_least_one(cfg_phase);
        case (p)
            PH_START_REL: begin
                sda_oe = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
            end
            PH_START_SDA:  sda_q = 1'b0;
            PH_START_SCL:  scl_q = 1'b0;
            PH_STOP_SDA:   sda_q = 1'b0;
            PH_STOP_SCL:   scl_q = 1'b1;
            PH_STOP_REL: begin
                sda_oe = 1'b0; sda_q = 1'b1;
            end
            PH_WR_HIGH: begin
                sda_oe = 1'b1; sda_q = shreg[7]; scl_q = 1'b1;
            end
            PH_WR_LOW:     scl_q = 1'b0;
            PH_WACK_HIGH: begin
                sda_oe = 1'b0; sda_q = 1'b1; scl_q = 1'b1;
            end
            PH_WACK_LOW:   scl_q = 1'b0;
            PH_RD_HIGH: begin
                sda_oe = 1'b0; sda_q = 1'b1; shreg = shreg << 1; scl_q = 1'b1;
            end
            PH_RD_LOW:     scl_q = 1'b0;
            PH_RACK_DRIVE: begin
                sda_oe = 1'b1; sda_q = ~ack_level;
            end
            PH_RACK_HIGH:  scl_q = 1'b1;
            PH_RACK_LOW:   scl_q = 1'b0;
            PH_UNS_LOW: begin
                sda_oe = 1'b1; scl_q = 1'b0; sda_q = 1'b0;
            end
            PH_UNS_HIGH: begin
                scl_q = 1'b1; sda_q = 1'b1;
            end
            PH_SETTLE: begin
                scl_q = 1'b1; sda_q = 1'b1; sda_oe = 1'b0;
                dly = at_least_one(cfg_setup);
            end
            default: ;
        endcase
    endfunction

    // closes a phase, samples sda where the bus protocol asks, picks the next phase
    function automatic phase_t end_phase(input phase_t p, input logic sda);
        case (p)
            PH_START_REL:  return PH_START_SDA;
            PH_START_SDA:  return PH_START_SCL;
            PH_START_SCL:  return (cur_cmd == ACT_ADDR) ? PH_WR_HIGH : PH_IDLE;
            PH_STOP_SDA:   return PH_STOP_SCL;
            PH_STOP_SCL:   return PH_STOP_REL;
            PH_WR_HIGH:    return PH_WR_LOW;
            PH_WR_LOW: begin
                shreg = shreg << 1;
                bits_left = bits_left - 4'd1;
                return (bits_left != 4'd0) ? PH_WR_HIGH : PH_WACK_HIGH;
            end
            PH_WACK_HIGH: begin
                acked = ~sda;
                return PH_WACK_LOW;
            end
            PH_RD_HIGH: begin
                if (sda) shreg[0] = 1'b1;
                return PH_RD_LOW;
            end
            PH_RD_LOW: begin
                bits_left = bits_left - 4'd1;
                return (bits_left != 4'd0) ? PH_RD_HIGH : PH_RACK_DRIVE;
            end
            PH_RACK_DRIVE: return PH_RACK_HIGH;
            PH_RACK_HIGH:  return PH_RACK_LOW;
            PH_RACK_LOW: begin
                sda_q = 1'b0;
                rx_byte = shreg;
                return PH_IDLE;
            end
            PH_UNS_LOW:    return PH_UNS_HIGH;
            PH_UNS_HIGH: begin
                pulses_left = pulses_left - 8'd1;
                return (pulses_left != 8'd0) ? PH_UNS_LOW : PH_IDLE;
            end
            PH_SETTLE:     return PH_START_REL;
            default:       return PH_IDLE;
        endcase
    endfunction

    function automatic pins_t step_engine(input logic [2:0] act, input logic [15:0] req);
        pins_t  r;
        phase_t nxt;
        logic [7:0] wbyte;
        wbyte = req[7:0];
        r = '0;
        if (act == ACT_TICK || act == ACT_TICK_ALT) begin
            if (cur_cmd != NO_CMD) begin
                dly = dly - 8'd1;
                if (dly == 8'd0) begin
                    nxt = end_phase(phase, req[10]);
                    if (nxt == PH_IDLE) begin
                        cur_cmd = NO_CMD;
                        phase = PH_IDLE;
                        r.done = 1'b1;
                    end else begin
                        begin_phase(nxt);
                    end
                end
            end
        end else if (cur_cmd != NO_CMD) begin
            r.error = 1'b1;
        end else begin
            cur_cmd = act;
            case (act)
                ACT_START: begin_phase(PH_START_REL);
                ACT_STOP:  begin_phase(PH_STOP_SDA);
                ACT_WRITE: begin
                    shreg = wbyte;
                    bits_left = 4'd8;
                    begin_phase(PH_WR_HIGH);
                end
                ACT_READ: begin
                    shreg = '0;
                    bits_left = 4'd8;
                    ack_level = req[8];
                    begin_phase(PH_RD_HIGH);
                end
                ACT_UNSTICK: begin
                    sda_oe = 1'b1;
                    pulses_left = cfg_pulses;
                    if (pulses_left == 8'd0) begin
                        cur_cmd = NO_CMD;
                        r.done = 1'b1;
                    end else begin
                        begin_phase(PH_UNS_LOW);
                    end
                end
                default: begin
                    shreg = {wbyte[7:1], req[9]};
                    bits_left = 4'd8;
                    begin_phase(PH_SETTLE);
                end
            endcase
        end
        r.scl       = scl_q;
        r.sda_out   = sda_q;
        r.sda_drive = sda_oe;
        r.busy      = (cur_cmd != NO_CMD);
        r.ack       = acked;
        r.read_data = rx_byte;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 40)
            $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_pins(input pins_t got, input pins_t want);
        if (got.scl !== want.scl)             report_mismatch("scl_out", got.scl, want.scl);
        if (got.sda_out !== want.sda_out)     report_mismatch("sda_out", got.sda_out, want.sda_out);
        if (got.sda_drive !== want.sda_drive) report_mismatch("sda_drive", got.sda_drive, want.sda_drive);
        if (got.busy !== want.busy)           report_mismatch("busy_res", got.busy, want.busy);
        if (got.done !== want.done)           report_mismatch("done_res", got.done, want.done);
        if (got.ack !== want.ack)             report_mismatch("ack_received", got.ack, want.ack);
        if (got.read_data !== want.read_data) report_mismatch("read_data", got.read_data, want.read_data);
        if (got.error !== want.error)         report_mismatch("error", got.error, want.error);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_engine();
            pins_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_PHASE_TICKS:    cfg_phase  = cfg_wdata;
                    CFG_SETUP_TICKS:    cfg_setup  = cfg_wdata;
                    CFG_UNSTICK_PULSES: cfg_pulses = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pins_due.push_back(step_engine(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (pins_due.size() == 0)
                    report_mismatch("unexpected result", m_tdata, 0);
                else
                    check_pins(pins_t'(m_tdata[14:0]), pins_due.pop_front());
            end
        end
        pending = pins_due.size();
        model_busy = (cur_cmd != NO_CMD);
    end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
module tb;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 40000;
    localparam int HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser = ACT_TICK;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = CFG_PHASE_TICKS;
    logic [7:0]  cfg_wdata = '0;

    int   fail_count, pending;
    logic model_busy;

    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;
    int   cycles = 0;
    int   reqs_sent = 0, cmds_sent = 0, refused_sent = 0, settings = 0;

    i2c_master_byte_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    i2c_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .model_busy(model_busy)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver: one long hold-off on request, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_req(input logic [2:0] act, input logic [7:0] wbyte,
                            input logic sack, input logic rflag, input logic sda);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        reqs_sent++;
        if (act != ACT_TICK && act != ACT_TICK_ALT) begin
            cmds_sent++;
            if (model_busy) refused_sent++;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, sda, rflag, sack, wbyte};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_tick();
        send_req(($urandom_range(15) == 0) ? ACT_TICK_ALT : ACT_TICK,
                 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
    endtask

    task automatic send_cmd(input logic [2:0] act);
        send_req(act, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
    endtask

    // tick until the engine is idle, with an occasional refused command as noise when noisy is set
    task automatic run_to_idle(input bit noisy);
        while (model_busy) begin
            if (noisy && $urandom_range(39) == 0)
                send_cmd(3'($urandom_range(ACT_START, ACT_ADDR)));
            else
                send_tick();
        end
    endtask

    task automatic configure(input logic [7:0] ph, input logic [7:0] st, input logic [7:0] pu);
        run_to_idle(1'b0);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_PHASE_TICKS;
        cfg_wdata <= ph;
        @(negedge aclk);
        cfg_addr <= CFG_SETUP_TICKS;
        cfg_wdata <= st;
        @(negedge aclk);
        cfg_addr <= CFG_UNSTICK_PULSES;
        cfg_wdata <= pu;
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
            1: begin src_idle_pct <= 48; sink_stall_pct <= 0;  end
            2: begin src_idle_pct <= 0;  sink_stall_pct <= 48; end
            default: begin src_idle_pct <= 14; sink_stall_pct <= 14; end
        endcase
    endtask

    task automatic run_random(input int n);
        int useful;
        useful = 0;
        while (useful < n) begin
            if (model_busy) begin
                if ($urandom_range(99) < 6) begin
                    send_cmd(3'($urandom_range(ACT_START, ACT_ADDR)));
                end else begin
                    send_tick();
                    useful++;
                end
            end else if ($urandom_range(99) < 75) begin
                send_cmd(3'($urandom_range(ACT_START, ACT_ADDR)));
                useful++;
            end else begin
                send_tick();
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // register defaults: idle ticks, start with a refused write, read,
        // addressed start, stop
        set_idling(3);
        send_req(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
        send_req(ACT_TICK_ALT, 8'hff, 1'b1, 1'b1, 1'b1);
        send_cmd(ACT_START);
        send_req(ACT_WRITE, 8'h3c, 1'b1, 1'b1, 1'b1);
        run_to_idle(1'b0);
        send_req(ACT_READ, 8'h00, 1'b1, 1'b0, 1'b1);
        run_to_idle(1'b0);
        send_req(ACT_ADDR, 8'ha5, 1'b0, 1'b1, 1'b0);
        run_to_idle(1'b0);
        send_cmd(ACT_STOP);
        run_to_idle(1'b0);

        // zero settings: delays act as one tick, unstick finishes at once
        configure(8'd0, 8'd0, 8'd0);
        send_cmd(ACT_UNSTICK);
        send_cmd(ACT_START);
        run_to_idle(1'b0);
        send_req(ACT_WRITE, 8'h81, 1'b0, 1'b0, 1'b1);
        run_to_idle(1'b0);
        send_cmd(ACT_STOP);
        run_to_idle(1'b0);

        // longest settle delay
        configure(8'd1, 8'd255, 8'd1);
        send_req(ACT_ADDR, 8'hff, 1'b1, 1'b0, 1'b0);
        run_to_idle(1'b0);
        send_cmd(ACT_UNSTICK);
        run_to_idle(1'b0);

        for (int mode = 0; mode < 4; mode++) begin
            for (int k = 0; k < 2; k++) begin
                configure(8'($urandom_range(0, 3)), 8'($urandom_range(0, 4)),
                          8'($urandom_range(0, 4)));
                set_idling(mode);
                if (mode == 2 && k == 0) hold_req <= 1'b1;
                run_random(100);
            end
        end

        run_to_idle(1'b1);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("tb: %0d requests sent, %0d of them commands (%0d refused while busy)",
                 reqs_sent, cmds_sent, refused_sent);
        $display("tb: %0d register settings incl. zero and longest settle, one %0d-cycle hold-off",
                 settings, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### files.f
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_queue.sv
src/i2cm_back.sv
src/i2c_master_byte_engine.sv
src/i2cm_checker.sv
verif/i2c_checker.sv
verif/tb.sv
